### rtl/terminal_line_editor_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the terminal line editor
// ----------------------------------------------------------------------------
`ifndef TERMINAL_LINE_EDITOR_UNIT_DEFINES_SVH
`define TERMINAL_LINE_EDITOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define TLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define TLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg
// Shared constants and types of the terminal line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

  // Line store geometry
  localparam int unsigned LINE_LEN = 32;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned ADDR_W   = $clog2(LINE_LEN);

  // Character codes
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_NUL = 8'h00;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_LINE = 2'd1,
    KIND_TERM = 2'd2
  } tle_kind_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ECHO,
    ST_BS1,
    ST_SP,
    ST_BS2,
    ST_CR,
    ST_LF,
    ST_LINE,
    ST_TERM
  } tle_state_e;

endpackage

### rtl/tle_in_if.sv
// ----------------------------------------------------------------------------
// tle_in_if
// Raw byte channel into the line editor, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;

  modport source (output valid, output raw_byte, input ready);
  modport sink   (input valid, input raw_byte, output ready);
endinterface

### rtl/tle_out_if.sv
// ----------------------------------------------------------------------------
// tle_out_if
// Result channel out of the line editor, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output kind, output out_byte, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

### rtl/terminal_line_editor_unit.sv
// ----------------------------------------------------------------------------
// terminal_line_editor_unit
// Canonical-mode line editor: CR/LF folding, line editing and echo.
// ----------------------------------------------------------------------------
// Usage:
//   raw_i  : one raw keyboard byte per transaction (valid/ready).
//   res_o  : result transactions {kind, out_byte, last}; last marks the final
//            result caused by one raw byte. Bytes that are swallowed (LF after
//            CR, ESC) produce no result.
//   line_limit_we_i/line_limit_i : write of the line size, only while idle.
// Timing:
//   A raw byte is taken while the sequencer is idle, then each result
//   leaves through a single output register, one per cycle when the
//   receiver is ready. An echo-only byte gives one result, a backspace BS,
//   SP, BS, and a newline CR, LF, the stored characters and a terminator;
//   the line walk reads the store, one entry per result, via its read port.
//   raw_i.ready is low while the sequencer emits; the next byte is accepted
//   as soon as the last result sits in the output register.
// Reset: line empty, CR flag clear, line size 32, no result pending. The line
//   store itself needs no clearing.
// Stall: a stalled receiver holds the output register and freezes the
//   sequencer; no result is dropped or repeated.
// ----------------------------------------------------------------------------
`include "terminal_line_editor_unit_defines.svh"

module terminal_line_editor_unit
  import tle_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                line_limit_we_i,
  input  logic [CNT_W-1:0]    line_limit_i,
  tle_in_if.sink              raw_i,
  tle_out_if.source           res_o
);

  tle_state_e        state_q, state_d;
  logic              cr_q, cr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  limit_q;
  logic [7:0]        echo_q, echo_d;
  logic              out_valid_q, out_valid_d;
  tle_kind_e         kind_q, kind_d;
  logic [7:0]        byte_q, byte_d;
  logic              last_q, last_d;
  logic [7:0]        mem_q [LINE_LEN];
  logic [7:0]        rd_q;
  logic              mem_we;
  logic              load;

  // normalized byte
  logic [7:0]        ch;
  logic              cr_norm;
  logic              drop;
  logic [CNT_W-1:0]  lim_cap;
  logic              room;

  // CR/LF folding
  always_comb begin
    ch      = raw_i.raw_byte;
    cr_norm = cr_q;
    drop    = 1'b0;
    priority if (cr_q) begin
      priority if (raw_i.raw_byte == CH_CR) begin
        ch = CH_LF;
      end else if (raw_i.raw_byte == CH_LF) begin
        cr_norm = 1'b0;
        drop    = 1'b1;
      end else begin
        cr_norm = 1'b0;
      end
    end else if (raw_i.raw_byte == CH_CR) begin
      cr_norm = 1'b1;
      ch      = CH_LF;
    end else begin
      cr_norm = 1'b0;
    end
  end

  // room check against the capped limit
  assign lim_cap = (limit_q > CNT_W'(LINE_LEN)) ? CNT_W'(LINE_LEN) : limit_q;
  assign room    = ({1'b0, count_q} + (CNT_W+1)'(1)) < {1'b0, lim_cap};

  assign load        = !out_valid_q || res_o.ready;
  assign raw_i.ready = (state_q == ST_IDLE);

  // sequencer: next state and output register loading
  always_comb begin
    state_d     = state_q;
    cr_d        = cr_q;
    count_d     = count_q;
    idx_d       = idx_q;
    echo_d      = echo_q;
    out_valid_d = out_valid_q && !res_o.ready;
    kind_d      = kind_q;
    byte_d      = byte_q;
    last_d      = last_q;
    mem_we      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (raw_i.valid) begin
          cr_d = cr_norm;
          if (!drop) begin
            priority if (ch == CH_ESC) begin
              cr_d = 1'b0;
            end else if (ch == CH_LF) begin
              idx_d   = '0;
              state_d = ST_CR;
            end else if (ch == CH_BS || ch == CH_DEL) begin
              if (count_q != '0) begin
                count_d = count_q - CNT_W'(1);
                state_d = ST_BS1;
              end else begin
                echo_d  = CH_BEL;
                state_d = ST_ECHO;
              end
            end else if (room) begin
              mem_we  = 1'b1;
              count_d = count_q + CNT_W'(1);
              echo_d  = ch;
              state_d = ST_ECHO;
            end else begin
              echo_d  = CH_BEL;
              state_d = ST_ECHO;
            end
          end
        end
      end
      ST_ECHO: begin
        if (load) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_ECHO;
          byte_d      = echo_q;
          last_d      = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_BS1: begin
        if (load) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_ECHO;
          byte_d      = CH_BS;
          last_d      = 1'b0;
          state_d     = ST_SP;
        end
      end
      ST_SP: begin
        if (load) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_ECHO;
          byte_d      = CH_SP;
          last_d      = 1'b0;
          state_d     = ST_BS2;
        end
      end
      ST_BS2: begin
        if (load) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_ECHO;
          byte_d      = CH_BS;
          last_d      = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_CR: begin
        if (load) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_ECHO;
          byte_d      = CH_CR;
          last_d      = 1'b0;
          state_d     = ST_LF;
        end
      end
      ST_LF: begin
        if (load) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_ECHO;
          byte_d      = CH_LF;
          last_d      = 1'b0;
          state_d     = (count_q == '0) ? ST_TERM : ST_LINE;
        end
      end
      ST_LINE: begin
        // walk the store, one entry per emitted result
        if (load) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_LINE;
          byte_d      = rd_q;
          last_d      = 1'b0;
          idx_d       = idx_q + CNT_W'(1);
          if (idx_d == count_q) begin
            state_d = ST_TERM;
          end
        end
      end
      ST_TERM: begin
        if (load) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_TERM;
          byte_d      = CH_NUL;
          last_d      = 1'b1;
          count_d     = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cr_q        <= 1'b0;
      count_q     <= '0;
      idx_q       <= '0;
      limit_q     <= CNT_W'(32);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cr_q        <= cr_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (line_limit_we_i) begin
        limit_q <= line_limit_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    echo_q <= echo_d;
    kind_q <= kind_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  // line store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[ADDR_W-1:0]] <= ch;
    end
    rd_q <= mem_q[idx_d[ADDR_W-1:0]];
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.kind     = kind_q;
  assign res_o.out_byte = byte_q;
  assign res_o.last     = last_q;

  // checks
  `TLE_ASSERT_NOW(a_count_in_range, 1'b1, count_q < CNT_W'(LINE_LEN),
                  "stored character count beyond the line store")
  `TLE_ASSERT_NOW(a_walk_in_line, state_q == ST_LINE, idx_q < count_q,
                  "line walk index past the stored characters")
  `TLE_ASSERT_NEXT(a_term_clears, state_q == ST_TERM && load, count_q == '0,
                   "line not cleared after the terminator")
  `TLE_ASSERT_NEXT(a_walk_result, state_q == ST_LINE && load,
                   out_valid_q && kind_q == KIND_LINE && !last_q,
                   "line walk step did not load a line byte")

endmodule

### dv/tb_terminal_line_editor_unit.sv
// ----------------------------------------------------------------------------
// tb_terminal_line_editor_unit
// Self-checking bench for the terminal line editor. Raw bytes go in over the
// valid/ready channel. A line-discipline predictor in the scoreboard folds
// CR/LF and tracks the line buffer. Every result transaction is compared
// field by field with the oldest predicted echo, line or terminator entry.
// Both sides stall at random, and one long receiver hold-off backs up the
// input. The line size is stepped through small, typical and out-of-range
// values.
// ----------------------------------------------------------------------------
module tb_terminal_line_editor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tle_pkg::*;

  localparam int unsigned HALF_PERIOD  = 4;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned SETTLE_CYC   = 40;    // covers a full newline walk
  localparam int unsigned IDLE_LIMIT   = 2000;  // cycles with no transaction
  localparam int unsigned HOLD_CYC     = 300;   // long receiver hold-off
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned NUM_PHASES   = 9;
  localparam int unsigned PHASE_W      = $clog2(NUM_PHASES);
  localparam int unsigned PHASE_ITEMS  = 25;

  typedef struct {
    tle_kind_e  kind;
    logic [7:0] data;
    logic       last;
  } editor_result_t;

  // Line discipline predictor and in-order result checker
  class line_editor_scoreboard;
    editor_result_t pending_results[$];
    editor_result_t step_results[$];
    bit             cr_seen;
    logic [7:0]     line_buf [LINE_LEN];
    int unsigned    char_cnt;
    int unsigned    line_size;
    int unsigned    mismatches;

    function new();
      cr_seen    = 1'b0;
      char_cnt   = 0;
      line_size  = LINE_LEN;
      mismatches = 0;
    endfunction

    function void set_line_size(logic [CNT_W-1:0] size);
      line_size = 32'(size);
    endfunction

    function void add(tle_kind_e kind, logic [7:0] data);
      editor_result_t r;
      r.kind = kind;
      r.data = data;
      r.last = 1'b0;
      step_results.push_back(r);
    endfunction

    // Predict the results of one accepted raw byte
    function void note_raw_byte(logic [7:0] raw);
      logic [7:0]  ch;
      int unsigned cap;
      ch = raw;
      step_results.delete();

      // CR/LF folding
      if (cr_seen) begin
        if (ch == CH_CR) begin
          ch = CH_LF;
        end else if (ch == CH_LF) begin
          cr_seen = 1'b0;
          return;
        end else begin
          cr_seen = 1'b0;
        end
      end else if (ch == CH_CR) begin
        cr_seen = 1'b1;
        ch      = CH_LF;
      end

      cap = (line_size > LINE_LEN) ? LINE_LEN : line_size;

      if (ch == CH_ESC) begin
        cr_seen = 1'b0;
        return;
      end else if (ch == CH_LF) begin
        add(KIND_ECHO, CH_CR);
        add(KIND_ECHO, CH_LF);
        for (int i = 0; i < char_cnt; i++) add(KIND_LINE, line_buf[ADDR_W'(i)]);
        add(KIND_TERM, CH_NUL);
        char_cnt = 0;
      end else if (ch == CH_BS || ch == CH_DEL) begin
        if (char_cnt != 0) begin
          char_cnt--;
          add(KIND_ECHO, CH_BS);
          add(KIND_ECHO, CH_SP);
          add(KIND_ECHO, CH_BS);
        end else begin
          add(KIND_ECHO, CH_BEL);
        end
      end else if (char_cnt + 1 < cap) begin
        line_buf[ADDR_W'(char_cnt)] = ch;
        char_cnt++;
        add(KIND_ECHO, ch);
      end else begin
        add(KIND_ECHO, CH_BEL);
      end

      step_results[step_results.size()-1].last = 1'b1;
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    endfunction

    // Compare one result transaction with the oldest prediction
    function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
      editor_result_t want;
      if (pending_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("[sb] unexpected result: kind=%0d byte=%02h last=%0b",
                   kind, data, last);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (kind !== want.kind || data !== want.data || last !== want.last) begin
        if (mismatches < MAX_REPORTS)
          $display("[sb] mismatch: exp kind=%0d byte=%02h last=%0b,",
                   want.kind, want.data, want.last,
                   " got kind=%0d byte=%02h last=%0b", kind, data, last);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             line_limit_we;
  logic [CNT_W-1:0] line_limit_d;

  tle_in_if  raw_if ();
  tle_out_if res_if ();

  line_editor_scoreboard sb;

  int unsigned xfer_cnt      = 0;
  int unsigned items_sent    = 0;
  int unsigned send_idle_max = 10;
  int unsigned recv_idle_max = 10;
  bit          hold_req      = 1'b0;

  terminal_line_editor_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .line_limit_we_i (line_limit_we),
    .line_limit_i    (line_limit_d),
    .raw_i           (raw_if),
    .res_o           (res_if)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Offer one raw byte; valid stays high if the next one follows at once
  task automatic send_raw(input logic [7:0] b);
    int unsigned gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap != 0) begin
      raw_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    raw_if.valid    <= 1'b1;
    raw_if.raw_byte <= b;
    do @(posedge clk_i); while (raw_if.ready !== 1'b1);
    sb.note_raw_byte(b);
    xfer_cnt++;
    items_sent++;
  endtask

  // Stop offering and let every predicted result come out
  task automatic drain();
    raw_if.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Line size write, only from an idle block
  task automatic set_line_size(input logic [CNT_W-1:0] size);
    drain();
    @(posedge clk_i);
    line_limit_we <= 1'b1;
    line_limit_d  <= size;
    @(posedge clk_i);
    line_limit_we <= 1'b0;
    sb.set_line_size(size);
  endtask

  // One typed line with random content and terminator, or a burst of noise
  task automatic type_random_line();
    int unsigned len;
    int unsigned r;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 4)) send_raw(8'($urandom_range(0, 255)));
    end else begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 8);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 80)      send_raw(8'($urandom_range(8'h20, 8'h7E)));
        else if (r < 90) send_raw(r[0] ? CH_BS : CH_DEL);
        else             send_raw(8'($urandom_range(0, 255)));
      end
      case ($urandom_range(0, 3))
        0: begin
          send_raw(CH_CR);
        end
        1: begin
          send_raw(CH_LF);
        end
        2: begin
          send_raw(CH_CR);
          send_raw(CH_LF);
        end
        default: begin
          send_raw(CH_CR);
          send_raw(CH_CR);
        end
      endcase
    end
  endtask

  // Result receiver with random stalls and one long hold-off
  initial begin
    int unsigned gap;
    int unsigned taken;
    taken = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (taken % 40 == 0) recv_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
      gap = $urandom_range(0, recv_idle_max);
      if (hold_req) begin
        hold_req = 1'b0;
        gap      = HOLD_CYC;
      end
      if (gap != 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
      sb.check_result(res_if.kind, res_if.out_byte, res_if.last);
      taken++;
      xfer_cnt++;
    end
  end

  // Watchdog on cycles without any transaction
  initial begin
    int unsigned idle_cycles;
    int unsigned seen;
    idle_cycles = 0;
    seen        = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (xfer_cnt != seen) begin
        seen        = xfer_cnt;
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  // Main sequence
  initial begin
    int unsigned phase_size [NUM_PHASES];
    phase_size = '{32, 63, 1, 0, 5, 2, 31, 17, 32};

    raw_if.valid    <= 1'b0;
    raw_if.raw_byte <= 8'h00;
    res_if.ready    <= 1'b0;
    line_limit_we   <= 1'b0;
    line_limit_d    <= '0;
    rst_ni          <= 1'b0;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Edits at the reset line size: NUL and 0xFF stored, erase to empty, beep
    send_raw("a");
    send_raw(8'h00);
    send_raw(8'hFF);
    send_raw(CH_BS);
    send_raw(CH_DEL);
    send_raw(CH_BS);
    send_raw(CH_BS);
    // CR newline, swallowed LF, then a lone LF
    send_raw(CH_CR);
    send_raw(CH_LF);
    send_raw(CH_LF);
    // CR CR gives two newlines; ESC drops the CR flag so LF is a newline
    send_raw("x");
    send_raw(CH_CR);
    send_raw(CH_CR);
    send_raw(CH_ESC);
    send_raw(CH_LF);
    // Line size lowered mid-line keeps the stored text
    send_raw("m");
    send_raw("n");
    send_raw("o");
    set_line_size(CNT_W'(2));
    send_raw("k");
    send_raw(CH_LF);
    // Zero line size stores nothing
    set_line_size(CNT_W'(0));
    send_raw("z");
    // Full line beeps
    set_line_size(CNT_W'(4));
    send_raw("a");
    send_raw("b");
    send_raw("c");
    send_raw("d");
    send_raw(CH_LF);

    // Random phases across line sizes, some with a back-to-back sender
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_line_size(CNT_W'(phase_size[PHASE_W'(p)]));
      send_idle_max = (p % 3 == 2) ? 0 : 10;
      if (p == 1) hold_req = 1'b1;
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) type_random_line();
    end

    drain();
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### terminal_line_editor_unit.f
+incdir+rtl
rtl/tle_pkg.sv
rtl/tle_in_if.sv
rtl/tle_out_if.sv
rtl/terminal_line_editor_unit.sv
dv/tb_terminal_line_editor_unit.sv
